// ----- src/error_code_pulse_serializer_macros.svh -----
// Assertion macros shared by the checker of the error code pulse serializer.
// Depends on nothing; every macro samples on a given clock and skips reset.
`ifndef ERROR_CODE_PULSE_SERIALIZER_MACROS_SVH
`define ERROR_CODE_PULSE_SERIALIZER_MACROS_SVH

// Property that must hold at every sampled edge outside reset.
`define ECPS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define ECPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ecps_pkg.sv -----
// Shared constants and types of the error code pulse serializer.
// Depends on nothing; imported by every module of the block.
package ecps_pkg;

  // Code and field widths.
  localparam int CODE_BITS = 16;
  localparam int BIT_W     = $clog2(CODE_BITS);
  localparam int DUR_W     = 10;
  localparam int RPT_W     = 4;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  // Bit positions that end a half frame and a whole frame.
  localparam logic [BIT_W-1:0] BIT_LAST     = BIT_W'(CODE_BITS - 1);
  localparam logic [BIT_W-1:0] BIT_HALF_END = BIT_W'(CODE_BITS / 2 - 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MARK       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PAUSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd5;

  // Register reset values.
  localparam logic [DUR_W-1:0] MARK_RST       = 10'd10;
  localparam logic [DUR_W-1:0] SPACE_RST      = 10'd10;
  localparam logic [DUR_W-1:0] BIT_RST        = 10'd80;
  localparam logic [DUR_W-1:0] HALF_PAUSE_RST = 10'd200;
  localparam logic [DUR_W-1:0] FRAME_GAP_RST  = 10'd800;
  localparam logic [RPT_W-1:0] REPEAT_RST     = 4'd3;

  // Phase codes of the pulse sequencer.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_MARK  = 3'd1;
  localparam logic [2:0] PH_SPACE = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_HALF  = 3'd4;
  localparam logic [2:0] PH_GAP   = 3'd5;

  // Input command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // One result item.
  typedef struct packed {
    logic pin_level;
    logic busy_res;
  } res_t;

endpackage

// ----- src/error_code_pulse_serializer.sv -----
// Top level of the error code pulse serializer: sequencer plus output buffer.
// Depends on ecps_pkg, ecps_core and ecps_skid.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------
//   input    | in_valid_i / in_stall_o   | cmd_i, code_i
//   result   | out_valid_o / out_stall_i | pin_level_o, busy_res_o
//   config   | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// Each item yields a registered result; one item per cycle unless the input stalls.
// The sequencer updates in the cycle of the transfer.
// Reset loads the register defaults and leaves the sequencer idle, no result offered.
// A stalled result is parked in a skid stage; the input stalls only while it is full.
module error_code_pulse_serializer
  import ecps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [CODE_BITS-1:0] code_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 pin_level_o,
  output logic                 busy_res_o
);

  logic accept;
  logic skid_full;
  res_t res, out_res;

  // An input transfer completes whenever the skid stage has room.
  assign accept     = in_valid_i && !skid_full;
  assign in_stall_o = skid_full;

  ecps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .code_i      (code_i),
    .res_o       (res)
  );

  ecps_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .full_o      (skid_full)
  );

  assign pin_level_o = out_res.pin_level;
  assign busy_res_o  = out_res.busy_res;

endmodule

// ----- src/ecps_core.sv -----
// Pulse sequencer and configuration registers of the error code pulse serializer.
// Depends on ecps_pkg; updates its state on each accepted transfer.
module ecps_core
  import ecps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 accept_i,
  input  logic                 cmd_i,
  input  logic [CODE_BITS-1:0] code_i,
  output res_t                 res_o
);

  // A zero duration still lasts one tick.
  function automatic logic [DUR_W-1:0] dur_load(input logic [DUR_W-1:0] t);
    return (t == '0) ? DUR_W'(1) : t;
  endfunction

  logic [DUR_W-1:0]     mark_q, space_q, bit_q, half_q, gap_q;
  logic [RPT_W-1:0]     repeat_q;
  logic [2:0]           phase_q, phase_d;
  logic [DUR_W-1:0]     ticks_q, ticks_d;
  logic [BIT_W-1:0]     bit_pos_q, bit_pos_d;
  logic [RPT_W-1:0]     frames_q, frames_d;
  logic [RPT_W-1:0]     frames_dec;
  logic [CODE_BITS-1:0] code_q, code_d;
  logic                 level_cur;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q   <= MARK_RST;
      space_q  <= SPACE_RST;
      bit_q    <= BIT_RST;
      half_q   <= HALF_PAUSE_RST;
      gap_q    <= FRAME_GAP_RST;
      repeat_q <= REPEAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MARK:       mark_q   <= cfg_data_i[DUR_W-1:0];
        REG_SPACE:      space_q  <= cfg_data_i[DUR_W-1:0];
        REG_BIT:        bit_q    <= cfg_data_i[DUR_W-1:0];
        REG_HALF_PAUSE: half_q   <= cfg_data_i[DUR_W-1:0];
        REG_FRAME_GAP:  gap_q    <= cfg_data_i[DUR_W-1:0];
        REG_REPEAT:     repeat_q <= cfg_data_i[RPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pin level shown by the current phase.
  always_comb begin
    case (phase_q)
      PH_MARK: level_cur = 1'b1;
      PH_DATA: level_cur = code_q[BIT_LAST - bit_pos_q];
      default: level_cur = 1'b0;
    endcase
  end

  // Result of the transfer: a start seen while idle shows the first mark at once.
  always_comb begin
    if (cmd_i == CMD_START) begin
      res_o.pin_level = (phase_q == PH_IDLE) ? 1'b1 : level_cur;
      res_o.busy_res  = 1'b1;
    end else begin
      res_o.pin_level = level_cur;
      res_o.busy_res  = (phase_q != PH_IDLE);
    end
  end

  assign frames_dec = (frames_q != '0) ? frames_q - RPT_W'(1) : frames_q;

  // Next state: a start while idle loads the frame, a tick counts down and steps the phase.
  always_comb begin
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    bit_pos_d = bit_pos_q;
    frames_d  = frames_q;
    code_d    = code_q;
    if (accept_i && cmd_i == CMD_START) begin
      if (phase_q == PH_IDLE) begin
        code_d    = code_i;
        bit_pos_d = '0;
        frames_d  = (repeat_q == '0) ? RPT_W'(1) : repeat_q;
        phase_d   = PH_MARK;
        ticks_d   = dur_load(mark_q);
      end
    end else if (accept_i && phase_q != PH_IDLE) begin
      if (ticks_q > DUR_W'(1)) begin
        ticks_d = ticks_q - DUR_W'(1);
      end else begin
        case (phase_q)
          PH_MARK: begin
            phase_d = PH_SPACE;
            ticks_d = dur_load(space_q);
          end
          PH_SPACE: begin
            phase_d = PH_DATA;
            ticks_d = dur_load(bit_q);
          end
          PH_DATA: begin
            if (bit_pos_q == BIT_LAST) begin
              bit_pos_d = '0;
              phase_d   = PH_GAP;
              ticks_d   = dur_load(gap_q);
            end else if (bit_pos_q == BIT_HALF_END) begin
              bit_pos_d = bit_pos_q + BIT_W'(1);
              phase_d   = PH_HALF;
              ticks_d   = dur_load(half_q);
            end else begin
              bit_pos_d = bit_pos_q + BIT_W'(1);
              phase_d   = PH_MARK;
              ticks_d   = dur_load(mark_q);
            end
          end
          PH_HALF: begin
            phase_d = PH_MARK;
            ticks_d = dur_load(mark_q);
          end
          PH_GAP: begin
            frames_d  = frames_dec;
            bit_pos_d = '0;
            if (frames_dec != '0) begin
              phase_d = PH_MARK;
              ticks_d = dur_load(mark_q);
            end else begin
              phase_d = PH_IDLE;
              ticks_d = '0;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            ticks_d = '0;
          end
        endcase
      end
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      ticks_q   <= '0;
      bit_pos_q <= '0;
      frames_q  <= '0;
      code_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      ticks_q   <= ticks_d;
      bit_pos_q <= bit_pos_d;
      frames_q  <= frames_d;
      code_q    <= code_d;
    end
  end

endmodule

// ----- src/ecps_skid.sv -----
// Output register with a skid stage for the result channel.
// Depends on ecps_pkg; holds up to two results so the input side keeps moving.
module ecps_skid
  import ecps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t out_data_o,
  output logic full_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_data_q, skid_data_q;
  logic out_free;

  // The output register can load when empty or when its result leaves now.
  assign out_free = !out_valid_q || !out_stall_i;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers follow the valid flags.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : push_data_i;
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign full_o      = skid_valid_q;

endmodule

// ----- src/ecps_checker.sv -----
// Port-level checker of the error code pulse serializer, bound to the top level.
// Depends on ecps_pkg and error_code_pulse_serializer_macros.svh.
`include "error_code_pulse_serializer_macros.svh"

module ecps_checker
  import ecps_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic cmd_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic pin_level_o,
  input logic busy_res_o
);

  logic out_held;
  logic idle_high;
  logic start_free;
  logic res_busy;

  // Port conditions the properties are built from.
  assign out_held   = out_valid_o && out_stall_i;
  assign idle_high  = out_valid_o && !busy_res_o && pin_level_o;
  assign start_free = in_valid_i && !in_stall_o && (cmd_i == CMD_START) && !out_held;
  assign res_busy   = out_valid_o && busy_res_o;

  // A result waiting on a stall stays offered.
  `ECPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o, "result dropped")

  // An idle pin is always low.
  `ECPS_ASSERT(a_idle_low, clk_i, rst_ni, !idle_high, "pin high while idle")

  // A start transfer with a free output shows busy in the next cycle.
  `ECPS_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_free, res_busy, "no busy after start")

  // The input stalls only while a result is offered.
  `ECPS_ASSERT(a_stall_cause, clk_i, rst_ni, !in_stall_o || out_valid_o, "stall without result")

endmodule

bind error_code_pulse_serializer ecps_checker u_checker (.*);
